>>> rtl/core/dbma_pkg.sv
`default_nettype none
package dbma_pkg;

    localparam int G_W        = 16;
    localparam int K_W        = 32;
    localparam int B_W        = 64;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DT_W       = 10;
    localparam int NUM_TERMS  = 6;
    localparam int TERM_W     = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FIRST   = 2'd0,
        FUNC_REFOCUS = 2'd1,
        FUNC_SECOND  = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_GAIN   = 2'd0,
        CFG_SECOND_GAIN  = 2'd1,
        CFG_DT_WEIGHT    = 2'd2,
        CFG_REFOCUS_TIME = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        W_UNIT    = 2'd0,
        W_REFOCUS = 2'd1,
        W_DT      = 2'd2
    } weight_sel_t;

    typedef struct packed {
        logic              accept;
        logic              gain_second;
        weight_sel_t       wsel;
        logic              k_update;
        logic              issue;
        logic [TERM_W-1:0] term;
        logic              negate;
        logic              mark_first;
        logic              mark_second;
        logic              emit;
        logic              clear;
    } dbma_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dbma_stat_t;

    typedef struct packed {
        logic signed [K_W-1:0] k_x;
        logic signed [K_W-1:0] k_y;
        logic signed [K_W-1:0] k_z;
        logic signed [B_W-1:0] b_xx;
        logic signed [B_W-1:0] b_yy;
        logic signed [B_W-1:0] b_zz;
        logic signed [B_W-1:0] b_xy;
        logic signed [B_W-1:0] b_xz;
        logic signed [B_W-1:0] b_yz;
        logic                  ok;
    } dbma_result_t;

endpackage
`default_nettype wire

>>> rtl/core/dbma_if.sv
`default_nettype none
interface dbma_item_if import dbma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic signed [G_W-1:0] gz;
    logic                  last;

    modport source (output valid, func, gx, gy, gz, last, input ready);
    modport sink (input valid, func, gx, gy, gz, last, output ready);
endinterface

interface dbma_result_if import dbma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [K_W-1:0] k_x;
    logic signed [K_W-1:0] k_y;
    logic signed [K_W-1:0] k_z;
    logic signed [B_W-1:0] b_xx;
    logic signed [B_W-1:0] b_yy;
    logic signed [B_W-1:0] b_zz;
    logic signed [B_W-1:0] b_xy;
    logic signed [B_W-1:0] b_xz;
    logic signed [B_W-1:0] b_yz;
    logic                  ok;

    modport source (output valid, k_x, k_y, k_z, b_xx, b_yy, b_zz, b_xy, b_xz, b_yz, ok,
                    input ready);
    modport sink (input valid, k_x, k_y, k_z, b_xx, b_yy, b_zz, b_xy, b_xz, b_yz, ok,
                  output ready);
endinterface

interface dbma_cfg_if import dbma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dbma_datapath.sv
`default_nettype none
module dbma_datapath import dbma_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 14,
    parameter int PRODUCT_SHIFT  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dbma_cmd_t             cmd,
    output dbma_stat_t                 stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [G_W-1:0] gx,
    input  wire logic signed [G_W-1:0] gy,
    input  wire logic signed [G_W-1:0] gz,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output dbma_result_t               res
);

    localparam logic signed [K_W-1:0] K_MAX = {1'b0, {(K_W-1){1'b1}}};
    localparam logic signed [K_W-1:0] K_MIN = {1'b1, {(K_W-1){1'b0}}};
    localparam logic signed [B_W-1:0] B_MAX = {1'b0, {(B_W-1){1'b1}}};
    localparam logic signed [B_W-1:0] B_MIN = {1'b1, {(B_W-1){1'b0}}};
    localparam int LO_W   = K_W + G_W;
    localparam int HI_W   = K_W + G_W + 1;
    localparam int FULL_W = B_W + G_W + 1;

    function automatic logic signed [K_W-1:0] sat_add32(
        input logic signed [K_W-1:0] a,
        input logic signed [K_W-1:0] b
    );
        logic signed [K_W:0] s;
        s = {a[K_W-1], a} + {b[K_W-1], b};
        if (s[K_W] != s[K_W-1])
            return s[K_W] ? K_MIN : K_MAX;
        return s[K_W-1:0];
    endfunction

    function automatic logic signed [B_W-1:0] sat_add64(
        input logic signed [B_W-1:0] a,
        input logic signed [B_W-1:0] b
    );
        logic signed [B_W:0] s;
        s = {a[B_W-1], a} + {b[B_W-1], b};
        if (s[B_W] != s[B_W-1])
            return s[B_W] ? B_MIN : B_MAX;
        return s[B_W-1:0];
    endfunction

    function automatic logic signed [K_W-1:0] sat_neg32(input logic signed [K_W-1:0] a);
        if (a == K_MIN)
            return K_MAX;
        return -a;
    endfunction

    // configuration registers
    logic signed [G_W-1:0]  first_gain_reg;
    logic signed [G_W-1:0]  second_gain_reg;
    logic [DT_W-1:0]        dt_weight_reg;
    logic [G_W-1:0]         refocus_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_gain_reg   <= 16'sd16384;
            second_gain_reg  <= 16'sd16384;
            dt_weight_reg    <= 10'd10;
            refocus_time_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FIRST_GAIN:   first_gain_reg   <= cfg_data;
                CFG_SECOND_GAIN:  second_gain_reg  <= cfg_data;
                CFG_DT_WEIGHT:    dt_weight_reg    <= cfg_data[DT_W-1:0];
                CFG_REFOCUS_TIME: refocus_time_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // item capture
    logic signed [G_W-1:0] g_x_reg, g_y_reg, g_z_reg;
    logic                  gain_second_reg;
    weight_sel_t           wsel_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            g_x_reg         <= gx;
            g_y_reg         <= gy;
            g_z_reg         <= gz;
            gain_second_reg <= cmd.gain_second;
            wsel_reg        <= cmd.wsel;
        end
    end

    // k-vector update, one lane per axis
    logic signed [K_W-1:0] k_x_reg, k_y_reg, k_z_reg;
    logic signed [K_W-1:0] k_x_next, k_y_next, k_z_next;
    logic signed [G_W-1:0] gain;
    logic signed [K_W-1:0] prod_x, prod_y, prod_z;
    logic signed [K_W-1:0] inc_x, inc_y, inc_z;

    always_comb
    begin
        gain   = gain_second_reg ? second_gain_reg : first_gain_reg;
        prod_x = gain * g_x_reg;
        prod_y = gain * g_y_reg;
        prod_z = gain * g_z_reg;
        inc_x  = prod_x >>> GAIN_FRAC_BITS;
        inc_y  = prod_y >>> GAIN_FRAC_BITS;
        inc_z  = prod_z >>> GAIN_FRAC_BITS;
        k_x_next = k_x_reg;
        k_y_next = k_y_reg;
        k_z_next = k_z_reg;
        if (cmd.clear)
        begin
            k_x_next = '0;
            k_y_next = '0;
            k_z_next = '0;
        end
        else if (cmd.k_update)
        begin
            k_x_next = sat_add32(k_x_reg, inc_x);
            k_y_next = sat_add32(k_y_reg, inc_y);
            k_z_next = sat_add32(k_z_reg, inc_z);
        end
        else if (cmd.negate)
        begin
            k_x_next = sat_neg32(k_x_reg);
            k_y_next = sat_neg32(k_y_reg);
            k_z_next = sat_neg32(k_z_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_x_reg <= '0;
            k_y_reg <= '0;
            k_z_reg <= '0;
        end
        else
        begin
            k_x_reg <= k_x_next;
            k_y_reg <= k_y_next;
            k_z_reg <= k_z_next;
        end
    end

    // outer-product pipeline: k_i*k_j, shifted product times weight in two halves, combine, accumulate
    logic signed [K_W-1:0]  op_a, op_b;
    logic [G_W-1:0]         weight;
    logic signed [B_W-1:0]  p1_reg;
    logic signed [B_W-1:0]  p_shift;
    logic [LO_W-1:0]        lo2_reg;
    logic signed [HI_W-1:0] hi2_reg;
    logic signed [FULL_W-1:0] full;
    logic signed [B_W-1:0]  t3_reg;
    logic signed [B_W-1:0]  t_sat;
    logic                   v1_reg, v2_reg, v3_reg;
    logic [TERM_W-1:0]      idx1_reg, idx2_reg, idx3_reg;

    always_comb
    begin
        case (cmd.term)
            3'd0:    begin op_a = k_x_reg; op_b = k_x_reg; end
            3'd1:    begin op_a = k_y_reg; op_b = k_y_reg; end
            3'd2:    begin op_a = k_z_reg; op_b = k_z_reg; end
            3'd3:    begin op_a = k_x_reg; op_b = k_y_reg; end
            3'd4:    begin op_a = k_x_reg; op_b = k_z_reg; end
            3'd5:    begin op_a = k_y_reg; op_b = k_z_reg; end
            default: begin op_a = '0;      op_b = '0;      end
        endcase
        case (wsel_reg)
            W_UNIT:    weight = G_W'(1);
            W_REFOCUS: weight = refocus_time_reg;
            W_DT:      weight = G_W'(dt_weight_reg);
            default:   weight = '0;
        endcase
        p_shift = p1_reg >>> PRODUCT_SHIFT;
        full    = $signed({hi2_reg, {K_W{1'b0}}}) + $signed({{(FULL_W-LO_W){1'b0}}, lo2_reg});
        // saturate the weighted term to 64 bits
        if (full[FULL_W-1:B_W-1] == {(FULL_W-B_W+1){full[B_W-1]}})
            t_sat = full[B_W-1:0];
        else
            t_sat = full[FULL_W-1] ? B_MIN : B_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= op_a * op_b;
        idx1_reg <= cmd.term;
        lo2_reg  <= p_shift[K_W-1:0] * weight;
        hi2_reg  <= $signed(p_shift[B_W-1:K_W]) * $signed({1'b0, weight});
        idx2_reg <= idx1_reg;
        t3_reg   <= t_sat;
        idx3_reg <= idx2_reg;
    end

    // b terms in the order xx yy zz xy xz yz
    logic signed [B_W-1:0] b_reg [NUM_TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
                b_reg[i] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
                b_reg[i] <= '0;
        end
        else if (v3_reg)
        begin
            b_reg[idx3_reg] <= sat_add64(b_reg[idx3_reg], t3_reg);
        end
    end

    // lobe flags
    logic seen_first_reg, seen_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg  <= 1'b0;
            seen_second_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            seen_first_reg  <= 1'b0;
            seen_second_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mark_first)
                seen_first_reg <= 1'b1;
            if (cmd.mark_second)
                seen_second_reg <= 1'b1;
        end
    end

    // result register
    dbma_result_t res_reg;
    logic         out_valid_reg;
    logic         ok;

    assign ok = seen_first_reg && (seen_second_reg || cmd.mark_second);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (ok)
            begin
                res_reg.k_x  <= k_x_reg;
                res_reg.k_y  <= k_y_reg;
                res_reg.k_z  <= k_z_reg;
                res_reg.b_xx <= b_reg[0];
                res_reg.b_yy <= b_reg[1];
                res_reg.b_zz <= b_reg[2];
                res_reg.b_xy <= b_reg[3];
                res_reg.b_xz <= b_reg[4];
                res_reg.b_yz <= b_reg[5];
                res_reg.ok   <= 1'b1;
            end
            else
            begin
                res_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign res            = res_reg;
    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

>>> rtl/core/dbma_ctrl.sv
`default_nettype none
module dbma_ctrl import dbma_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire logic [FUNC_W-1:0] item_func,
    input  wire logic              item_last,
    input  wire dbma_stat_t        stat,
    output dbma_cmd_t              cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KUPD  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic              last_reg, last_next;
    logic [TERM_W-1:0] term_reg, term_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        last_next  = last_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.wsel   = W_UNIT;
        cmd.term   = term_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept      = 1'b1;
                    func_next       = func_t'(item_func);
                    last_next       = item_last;
                    term_next       = '0;
                    cmd.gain_second = (func_t'(item_func) == FUNC_SECOND);
                    case (func_t'(item_func))
                        FUNC_FIRST:
                        begin
                            cmd.wsel   = W_UNIT;
                            state_next = S_KUPD;
                        end
                        FUNC_REFOCUS:
                        begin
                            cmd.wsel   = W_REFOCUS;
                            state_next = S_ISSUE;
                        end
                        FUNC_SECOND:
                        begin
                            cmd.wsel   = W_DT;
                            state_next = S_KUPD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_KUPD:
            begin
                cmd.k_update = 1'b1;
                state_next   = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (term_reg == TERM_W'(NUM_TERMS - 1))
                    state_next = S_DRAIN;
                else
                    term_next = term_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                case (func_reg)
                    FUNC_FIRST:
                    begin
                        cmd.mark_first = 1'b1;
                        state_next     = S_IDLE;
                    end
                    FUNC_REFOCUS:
                    begin
                        cmd.negate = 1'b1;
                        state_next = S_IDLE;
                    end
                    FUNC_SECOND:
                    begin
                        // a closing beat waits here until the result register is free
                        if (!last_reg)
                        begin
                            cmd.mark_second = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.mark_second = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.clear       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= FUNC_FIRST;
            last_reg  <= 1'b0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            last_reg  <= last_next;
            term_reg  <= term_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/diffusion_bmatrix_accumulator.sv
// diffusion b-matrix accumulator
// item channel (valid/ready): func, gx, gy, gz, last. func 0 adds a first-lobe
// sample, 1 applies the refocus step, 2 adds a second-lobe sample, 3 clears.
// result channel (valid/ready): k_x..k_z, the six b terms and ok, one beat for
// each second-lobe beat with last set; ok low means an empty lobe and zero fields.
// cfg channel (valid/ready, always ready): index and data; 0 first_gain,
// 1 second_gain, 2 dt_weight, 3 refocus_time.
// one beat is worked on at a time. a sample beat goes through one k update, six
// outer-product terms issued one a cycle into a single 32x32 multiplier, a
// pipeline drain and a final step. refocus skips the k update, and clear goes
// straight to the final step.
// the result appears in the cycle after the final step and sits in an output
// register; a stalled receiver only holds the block when a second result is
// due while the first has not been taken.
// reset clears k, b and the lobe flags and loads the register defaults.
`default_nettype none
module diffusion_bmatrix_accumulator import dbma_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 14,
    parameter int PRODUCT_SHIFT  = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dbma_item_if.sink     item,
    dbma_result_if.source result,
    dbma_cfg_if.sink      cfg
);

    dbma_cmd_t    cmd;
    dbma_stat_t   stat;
    dbma_result_t res;
    logic         out_valid;

    assign cfg.ready = 1'b1;

    dbma_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_func  (item.func),
        .item_last  (item.last),
        .stat       (stat),
        .cmd        (cmd)
    );

    dbma_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .PRODUCT_SHIFT  (PRODUCT_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .gx        (item.gx),
        .gy        (item.gy),
        .gz        (item.gz),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .res       (res)
    );

    assign result.valid = out_valid;
    assign result.k_x   = res.k_x;
    assign result.k_y   = res.k_y;
    assign result.k_z   = res.k_z;
    assign result.b_xx  = res.b_xx;
    assign result.b_yy  = res.b_yy;
    assign result.b_zz  = res.b_zz;
    assign result.b_xy  = res.b_xy;
    assign result.b_xz  = res.b_xz;
    assign result.b_yz  = res.b_yz;
    assign result.ok    = res.ok;

    // no beat is taken while outer-product terms are still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> !stat.pipe_busy)
        else $error("item accepted with pipeline busy");

    // a new result never overwrites one the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready))
        else $error("result overwritten");

    // terms are issued only while the input side is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !item.ready)
        else $error("term issued while ready");

    // result valid only rises after an emit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.emit))
        else $error("result valid without emit");

endmodule
`default_nettype wire
